// ===== hw/rtl/pnm_image_stream_parser_assert.svh =====
// assertion macros for the pnm parser checker
`ifndef PNM_IMAGE_STREAM_PARSER_ASSERT_SVH
`define PNM_IMAGE_STREAM_PARSER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define PNM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define PNM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pnm_pkg.sv =====
package pnm_pkg;

    localparam int DIM_BITS = 16;
    localparam int ACC_W    = ((DIM_BITS > 16) ? DIM_BITS : 16) + 1;

    localparam logic [ACC_W-1:0] DIM_MAX    = ACC_W'((64'd1 << DIM_BITS) - 64'd1);
    localparam logic [ACC_W-1:0] MAXVAL_MAX = ACC_W'(65535);
    localparam logic [ACC_W-1:0] ACC_CAP    = {ACC_W{1'b1}};
    localparam logic [15:0]      BYTE_MAX   = 16'd255;
    localparam logic [1:0]       LAST_PLANE = 2'd2;

    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_5    = 8'h35;
    localparam logic [7:0] CH_6    = 8'h36;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_BIN,
        PH_ASCII,
        PH_TAIL,
        PH_FAIL
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_SAMPLE,
        KIND_DONE,
        KIND_ERROR
    } t_kind;

    typedef enum logic [1:0] {
        FMT_P5 = 2'd0,
        FMT_P6 = 2'd1,
        FMT_P3 = 2'd2
    } t_format;

    typedef enum logic [1:0] {
        MG_START,
        MG_GOT_P,
        MG_OK,
        MG_BAD
    } t_magic;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_MAGIC,
        ERR_HDR_CUT,
        ERR_NUMBER,
        ERR_ZERO_DIM,
        ERR_MAXVAL,
        ERR_DATA_CUT,
        ERR_TOO_LARGE
    } t_error;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] sample_value;
        logic [1:0]  channel;
        logic [15:0] column;
        logic [15:0] row;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] max_value;
        t_format     format;
        logic        wide_samples;
        t_error      error_code;
        logic        last_of_run;
    } t_result;

endpackage

// ===== hw/rtl/pnm_image_stream_parser.sv =====
// PNM (P3, P5, P6) byte stream parser.
// Input channel: one file byte per transfer (i_data_byte), i_end_of_file set
// on the final byte. Output channel: one result per transfer: a header after
// a valid maxval, then each sample as it completes, and done or error on the
// final byte. A byte causes zero, one or two results.
// Each accepted byte is handled in the cycle it is taken: parser state and
// result register update on that edge, and a result is offered on o_out_valid
// once every result queued ahead of it has been taken.
// Throughput is one byte per cycle while o_in_ready is high. Results queue
// in a three entry output buffer; o_in_ready is high while at most one result
// waits, so a stalled receiver holds bytes back only once two results are
// pending, and a final byte that yields two results puts both in the buffer.
// Errors are held and reported at end of file; the parser then returns to
// its reset state for the next file.
// Reset (i_rst_n low, synchronous) clears the parser and empties the buffer.
module pnm_image_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_sample_value,
    output logic [1:0]  o_channel,
    output logic [15:0] o_column,
    output logic [15:0] o_row,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic [15:0] o_max_value,
    output logic [1:0]  o_format,
    output logic        o_wide_samples,
    output logic [2:0]  o_error_code,
    output logic        o_last_of_run
);
    import pnm_pkg::*;

    t_phase              r_phase, n_phase;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic                r_tok_active, n_tok_active;
    logic                r_tok_invalid, n_tok_invalid;
    logic                r_in_comment, n_in_comment;
    t_magic              r_magic, n_magic;
    t_format             r_format, n_format;
    logic [DIM_BITS-1:0] r_width, n_width;
    logic [DIM_BITS-1:0] r_height, n_height;
    logic [15:0]         r_maxval, n_maxval;
    logic [DIM_BITS-1:0] r_col, n_col;
    logic [DIM_BITS-1:0] r_row, n_row;
    logic [1:0]          r_chan, n_chan;
    logic [7:0]          r_high_byte, n_high_byte;
    logic                r_high_held, n_high_held;
    t_error              r_pending, n_pending;

    t_result             r_fifo [3];
    logic [1:0]          r_wp, n_wp;
    logic [1:0]          r_rp, n_rp;
    logic [1:0]          r_count, n_count;

    logic                accept;
    logic                pop;
    logic                is_ws;
    logic                is_hash;
    logic                is_digit;
    logic                tok_phase;
    logic                wide_cur;
    logic [ACC_W+3:0]    acc_mul;
    logic [ACC_W-1:0]    acc_next;
    logic [DIM_BITS:0]   col_inc;
    logic [DIM_BITS:0]   row_inc;

    logic                end_req;
    logic                end_now;
    logic [ACC_W-1:0]    tok_val;
    logic                tok_bad;
    t_error              hdr_err;
    t_error              pend_c;
    logic                samp_req;
    logic [15:0]         samp_val;
    logic                pre_vld;
    logic                fin_vld;
    t_result             pre_res;
    t_result             fin_res;

    function automatic logic [1:0] inc3(input logic [1:0] p);
        return (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    assign accept   = i_in_valid && o_in_ready;
    assign is_ws    = (i_data_byte == CH_SP) || (i_data_byte == CH_TAB) ||
                      (i_data_byte == CH_LF) || (i_data_byte == CH_CR);
    assign is_hash  = (i_data_byte == CH_HASH);
    assign is_digit = (i_data_byte >= CH_0) && (i_data_byte <= CH_9);
    assign tok_phase = (r_phase == PH_MAGIC) || (r_phase == PH_WIDTH) ||
                       (r_phase == PH_HEIGHT) || (r_phase == PH_MAXVAL) ||
                       (r_phase == PH_ASCII);
    assign wide_cur = (r_maxval > BYTE_MAX);

    // acc * 10 + digit
    assign acc_mul = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} +
                     (ACC_W+4)'(i_data_byte - CH_0);

    always_comb begin
        if (r_phase == PH_ASCII) begin
            acc_next = ACC_W'(acc_mul[15:0]);
        end else if (acc_mul > (ACC_W+4)'(ACC_CAP)) begin
            acc_next = ACC_CAP;
        end else begin
            acc_next = acc_mul[ACC_W-1:0];
        end
    end

    assign col_inc = {1'b0, r_col} + (DIM_BITS+1)'(1);
    assign row_inc = {1'b0, r_row} + (DIM_BITS+1)'(1);

    always_comb begin
        n_phase       = r_phase;
        n_acc         = r_acc;
        n_tok_active  = r_tok_active;
        n_tok_invalid = r_tok_invalid;
        n_in_comment  = r_in_comment;
        n_magic       = r_magic;
        n_format      = r_format;
        n_width       = r_width;
        n_height      = r_height;
        n_maxval      = r_maxval;
        n_col         = r_col;
        n_row         = r_row;
        n_chan        = r_chan;
        n_high_byte   = r_high_byte;
        n_high_held   = r_high_held;
        n_pending     = r_pending;
        end_req  = 1'b0;
        end_now  = 1'b0;
        tok_val  = '0;
        tok_bad  = 1'b0;
        hdr_err  = ERR_NONE;
        pend_c   = ERR_NONE;
        samp_req = 1'b0;
        samp_val = '0;
        pre_vld  = 1'b0;
        fin_vld  = 1'b0;
        pre_res  = '0;
        fin_res  = '0;

        if (accept) begin
            // byte handling
            if (tok_phase) begin
                if (r_in_comment) begin
                    if (i_data_byte == CH_LF) begin
                        n_in_comment = 1'b0;
                    end
                end else if (is_hash || is_ws) begin
                    end_req = r_tok_active;
                    if (is_hash) begin
                        n_in_comment = 1'b1;
                    end
                end else begin
                    n_tok_active = 1'b1;
                    if (r_phase == PH_MAGIC) begin
                        case (r_magic)
                            MG_START: begin
                                n_magic = (i_data_byte == CH_P) ? MG_GOT_P : MG_BAD;
                            end
                            MG_GOT_P: begin
                                n_magic = MG_OK;
                                case (i_data_byte)
                                    CH_5:    n_format = FMT_P5;
                                    CH_6:    n_format = FMT_P6;
                                    CH_3:    n_format = FMT_P3;
                                    default: n_magic  = MG_BAD;
                                endcase
                            end
                            default: n_magic = MG_BAD;
                        endcase
                    end else if (is_digit) begin
                        n_acc = acc_next;
                    end else begin
                        n_tok_invalid = 1'b1;
                    end
                end
            end else if (r_phase == PH_BIN) begin
                if (r_in_comment) begin
                    if (i_data_byte == CH_LF) begin
                        n_in_comment = 1'b0;
                    end
                end else if (wide_cur) begin
                    if (!r_high_held) begin
                        n_high_byte = i_data_byte;
                        n_high_held = 1'b1;
                    end else begin
                        n_high_held = 1'b0;
                        samp_req    = 1'b1;
                        samp_val    = {r_high_byte, i_data_byte};
                    end
                end else begin
                    samp_req = 1'b1;
                    samp_val = {8'h00, i_data_byte};
                end
            end

            // token end, by separator or by end of file in the maxval or ASCII phase
            end_now = end_req || (i_end_of_file && n_tok_active &&
                      ((r_phase == PH_MAXVAL) || (r_phase == PH_ASCII)));

            if (end_now) begin
                tok_val       = n_acc;
                tok_bad       = n_tok_invalid;
                n_acc         = '0;
                n_tok_invalid = 1'b0;
                n_tok_active  = 1'b0;
                case (r_phase)
                    PH_MAGIC: begin
                        if (n_magic == MG_OK) begin
                            n_phase = PH_WIDTH;
                        end else begin
                            if (r_pending == ERR_NONE) begin
                                n_pending = ERR_MAGIC;
                            end
                            n_phase = PH_FAIL;
                        end
                        n_magic = MG_START;
                    end
                    PH_WIDTH, PH_HEIGHT: begin
                        if (r_pending == ERR_NONE) begin
                            if (tok_bad) begin
                                n_pending = ERR_NUMBER;
                            end else if (tok_val > DIM_MAX) begin
                                n_pending = ERR_TOO_LARGE;
                            end
                        end
                        if (r_phase == PH_WIDTH) begin
                            n_width = (tok_val > DIM_MAX) ? DIM_MAX[DIM_BITS-1:0]
                                                          : tok_val[DIM_BITS-1:0];
                            n_phase = PH_HEIGHT;
                        end else begin
                            n_height = (tok_val > DIM_MAX) ? DIM_MAX[DIM_BITS-1:0]
                                                           : tok_val[DIM_BITS-1:0];
                            n_phase  = PH_MAXVAL;
                        end
                    end
                    PH_MAXVAL: begin
                        hdr_err = r_pending;
                        if (hdr_err == ERR_NONE && tok_bad) begin
                            hdr_err = ERR_NUMBER;
                        end
                        if (hdr_err == ERR_NONE && (r_width == '0 || r_height == '0)) begin
                            hdr_err = ERR_ZERO_DIM;
                        end
                        if (hdr_err == ERR_NONE && (tok_val == '0 || tok_val > MAXVAL_MAX)) begin
                            hdr_err = ERR_MAXVAL;
                        end
                        if (hdr_err != ERR_NONE) begin
                            n_pending = hdr_err;
                            n_phase   = PH_FAIL;
                        end else begin
                            n_maxval             = tok_val[15:0];
                            pre_vld              = 1'b1;
                            pre_res.kind         = KIND_HEADER;
                            pre_res.image_width  = 16'(r_width);
                            pre_res.image_height = 16'(r_height);
                            pre_res.max_value    = tok_val[15:0];
                            pre_res.format       = r_format;
                            pre_res.wide_samples = (tok_val[15:0] > BYTE_MAX);
                            n_col       = '0;
                            n_row       = '0;
                            n_chan      = '0;
                            n_high_held = 1'b0;
                            n_phase     = (r_format == FMT_P3) ? PH_ASCII : PH_BIN;
                        end
                    end
                    PH_ASCII: begin
                        if (tok_bad) begin
                            if (r_pending == ERR_NONE) begin
                                n_pending = ERR_NUMBER;
                            end
                            n_phase = PH_FAIL;
                        end else begin
                            samp_req = 1'b1;
                            samp_val = tok_val[15:0];
                        end
                    end
                    default: ;
                endcase
            end

            // sample out and raster position
            if (samp_req) begin
                pre_vld              = 1'b1;
                pre_res.kind         = KIND_SAMPLE;
                pre_res.sample_value = samp_val;
                pre_res.channel      = r_chan;
                pre_res.column       = 16'(r_col);
                pre_res.row          = 16'(r_row);
                pre_res.format       = r_format;
                pre_res.wide_samples = wide_cur;
                if ((r_format == FMT_P5) || (r_chan == LAST_PLANE)) begin
                    n_chan = '0;
                    if (col_inc >= {1'b0, r_width}) begin
                        n_col = '0;
                        n_row = row_inc[DIM_BITS-1:0];
                        if (row_inc >= {1'b0, r_height}) begin
                            n_phase = PH_TAIL;
                        end
                    end else begin
                        n_col = col_inc[DIM_BITS-1:0];
                    end
                end else begin
                    n_chan = r_chan + 2'd1;
                end
            end

            // end of file
            if (i_end_of_file) begin
                pend_c = n_pending;
                case (n_phase)
                    PH_MAGIC: begin
                        pend_c = (n_tok_active && n_magic == MG_OK) ? ERR_HDR_CUT : ERR_MAGIC;
                    end
                    PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                        pend_c = ERR_HDR_CUT;
                    end
                    PH_BIN, PH_ASCII: begin
                        if (pend_c == ERR_NONE) begin
                            pend_c = ERR_DATA_CUT;
                        end
                    end
                    default: ;
                endcase
                fin_vld             = 1'b1;
                fin_res.kind        = (pend_c != ERR_NONE) ? KIND_ERROR : KIND_DONE;
                fin_res.error_code  = pend_c;
                fin_res.last_of_run = 1'b1;

                n_phase       = PH_MAGIC;
                n_acc         = '0;
                n_tok_active  = 1'b0;
                n_tok_invalid = 1'b0;
                n_in_comment  = 1'b0;
                n_magic       = MG_START;
                n_format      = FMT_P5;
                n_width       = '0;
                n_height      = '0;
                n_maxval      = '0;
                n_col         = '0;
                n_row         = '0;
                n_chan        = '0;
                n_high_byte   = '0;
                n_high_held   = 1'b0;
                n_pending     = ERR_NONE;
            end
        end

        pre_res.last_of_run = !fin_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_MAGIC;
            r_acc         <= '0;
            r_tok_active  <= 1'b0;
            r_tok_invalid <= 1'b0;
            r_in_comment  <= 1'b0;
            r_magic       <= MG_START;
            r_format      <= FMT_P5;
            r_width       <= '0;
            r_height      <= '0;
            r_maxval      <= '0;
            r_col         <= '0;
            r_row         <= '0;
            r_chan        <= '0;
            r_high_byte   <= '0;
            r_high_held   <= 1'b0;
            r_pending     <= ERR_NONE;
        end else begin
            r_phase       <= n_phase;
            r_acc         <= n_acc;
            r_tok_active  <= n_tok_active;
            r_tok_invalid <= n_tok_invalid;
            r_in_comment  <= n_in_comment;
            r_magic       <= n_magic;
            r_format      <= n_format;
            r_width       <= n_width;
            r_height      <= n_height;
            r_maxval      <= n_maxval;
            r_col         <= n_col;
            r_row         <= n_row;
            r_chan        <= n_chan;
            r_high_byte   <= n_high_byte;
            r_high_held   <= n_high_held;
            r_pending     <= n_pending;
        end
    end

    // output buffer
    assign o_in_ready  = (r_count <= 2'd1);
    assign o_out_valid = (r_count != 2'd0);
    assign pop         = o_out_valid && i_out_ready;

    always_comb begin
        n_rp    = pop ? inc3(r_rp) : r_rp;
        n_wp    = r_wp;
        n_count = r_count + {1'b0, pre_vld} + {1'b0, fin_vld} - {1'b0, pop};
        if (pre_vld && fin_vld) begin
            n_wp = inc3(inc3(r_wp));
        end else if (pre_vld || fin_vld) begin
            n_wp = inc3(r_wp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pre_vld) begin
            r_fifo[r_wp] <= pre_res;
        end else if (fin_vld) begin
            r_fifo[r_wp] <= fin_res;
        end
        if (pre_vld && fin_vld) begin
            r_fifo[inc3(r_wp)] <= fin_res;
        end
    end

    assign o_kind         = r_fifo[r_rp].kind;
    assign o_sample_value = r_fifo[r_rp].sample_value;
    assign o_channel      = r_fifo[r_rp].channel;
    assign o_column       = r_fifo[r_rp].column;
    assign o_row          = r_fifo[r_rp].row;
    assign o_image_width  = r_fifo[r_rp].image_width;
    assign o_image_height = r_fifo[r_rp].image_height;
    assign o_max_value    = r_fifo[r_rp].max_value;
    assign o_format       = r_fifo[r_rp].format;
    assign o_wide_samples = r_fifo[r_rp].wide_samples;
    assign o_error_code   = r_fifo[r_rp].error_code;
    assign o_last_of_run  = r_fifo[r_rp].last_of_run;

endmodule

// ===== hw/rtl/pnm_chk.sv =====
`include "pnm_image_stream_parser_assert.svh"

module pnm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_end_of_file,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [15:0] o_sample_value,
    input logic [1:0]  o_channel,
    input logic [15:0] o_column,
    input logic [15:0] o_row,
    input logic [15:0] o_image_width,
    input logic [15:0] o_image_height,
    input logic [15:0] o_max_value,
    input logic [1:0]  o_format,
    input logic        o_wide_samples,
    input logic [2:0]  o_error_code,
    input logic        o_last_of_run
);
    import pnm_pkg::*;

    // stalled result holds
    `PNM_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_kind) && $stable(o_sample_value) && $stable(o_error_code) && $stable(o_last_of_run), "result changed while stalled")

    // final byte always produces a result
    `PNM_ASSERT_NXT(a_eof_result, i_in_valid && o_in_ready && i_end_of_file, o_out_valid, "no result after final byte")

    // position fields only in samples
    `PNM_ASSERT_IMP(a_pos_zero, o_out_valid && o_kind != KIND_SAMPLE, o_sample_value == 16'd0 && o_column == 16'd0 && o_row == 16'd0 && o_channel == 2'd0, "position set outside sample")

    // error code present exactly on error results
    `PNM_ASSERT_IMP(a_err_code, o_out_valid, (o_kind == KIND_ERROR) == (o_error_code != ERR_NONE), "error code mismatch")

    // done and error close the run
    `PNM_ASSERT_IMP(a_end_last, o_out_valid && (o_kind == KIND_DONE || o_kind == KIND_ERROR), o_last_of_run, "end result not last")

endmodule

bind pnm_image_stream_parser pnm_chk u_pnm_chk (.*);

// ===== sim/pnm_image_stream_parser_tb.sv =====
`timescale 1ns / 100ps

module pnm_image_stream_parser_tb;
    import pnm_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          PHASE_BYTES    = 200;
    localparam logic [63:0] DIM_LIMIT      = (64'd1 << DIM_BITS) - 64'd1;
    localparam logic [63:0] SAMPLE_LIMIT   = 64'd65535;
    localparam logic [63:0] ACC_LIMIT      = 64'h1_FFFF_FFFF;

    typedef struct {
        logic [7:0] data;
        logic       eof;
        bit         drain_first;
    } t_file_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_end_of_file = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [15:0] o_sample_value;
    logic [1:0]  o_channel;
    logic [15:0] o_column;
    logic [15:0] o_row;
    logic [15:0] o_image_width;
    logic [15:0] o_image_height;
    logic [15:0] o_max_value;
    logic [1:0]  o_format;
    logic        o_wide_samples;
    logic [2:0]  o_error_code;
    logic        o_last_of_run;

    pnm_image_stream_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_file  (i_end_of_file),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_sample_value (o_sample_value),
        .o_channel      (o_channel),
        .o_column       (o_column),
        .o_row          (o_row),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_max_value    (o_max_value),
        .o_format       (o_format),
        .o_wide_samples (o_wide_samples),
        .o_error_code   (o_error_code),
        .o_last_of_run  (o_last_of_run)
    );

    // parser shadow state
    t_phase      ph;
    logic [63:0] acc;
    bit          tok_active;
    bit          tok_bad;
    bit          comment_open;
    t_magic      magic;
    t_format     fmt;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [31:0] img_max;
    logic [31:0] col;
    logic [31:0] row;
    logic [1:0]  plane;
    logic [7:0]  hi_byte;
    bit          hi_held;
    t_error      err;

    t_result     byte_out[$];
    t_result     parsed_results[$];
    t_file_byte  file_stream[$];
    logic [7:0]  file_buf[$];
    t_file_byte  next_byte;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int stuck_cycles = 0;

    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function void clear_parser();
        ph = PH_MAGIC;
        acc = 64'd0;
        tok_active = 1'b0;
        tok_bad = 1'b0;
        comment_open = 1'b0;
        magic = MG_START;
        fmt = FMT_P5;
        img_w = 32'd0;
        img_h = 32'd0;
        img_max = 32'd0;
        col = 32'd0;
        row = 32'd0;
        plane = 2'd0;
        hi_byte = 8'd0;
        hi_held = 1'b0;
        err = ERR_NONE;
    endfunction

    function void add_result(t_kind k, logic [15:0] sv, logic [1:0] ch, logic [15:0] c,
                             logic [15:0] r, logic [15:0] w, logic [15:0] h,
                             logic [15:0] mv, t_format f, logic wide, t_error e);
        t_result res;
        if (byte_out.size() >= 2) return;
        res.kind = k;
        res.sample_value = sv;
        res.channel = ch;
        res.column = c;
        res.row = r;
        res.image_width = w;
        res.image_height = h;
        res.max_value = mv;
        res.format = f;
        res.wide_samples = wide;
        res.error_code = e;
        res.last_of_run = 1'b0;
        byte_out.insert(byte_out.size(), res);
    endfunction

    function void note_error(t_error e);
        if (err == ERR_NONE) err = e;
    endfunction

    function void abort_with(t_error e);
        note_error(e);
        ph = PH_FAIL;
    endfunction

    function void emit_pixel(logic [15:0] v);
        logic [1:0] planes;
        planes = (fmt == FMT_P5) ? 2'd1 : 2'd3;
        add_result(KIND_SAMPLE, v, plane, col[15:0], row[15:0], 16'd0, 16'd0, 16'd0,
                   fmt, img_max > 32'd255, ERR_NONE);
        plane = plane + 2'd1;
        if (plane >= planes) begin
            plane = 2'd0;
            col = col + 32'd1;
            if (col >= img_w) begin
                col = 32'd0;
                row = row + 32'd1;
                if (row >= img_h) ph = PH_TAIL;
            end
        end
    endfunction

    function void close_token();
        logic [63:0] v;
        bit          bad;
        v = acc;
        bad = tok_bad;
        acc = 64'd0;
        tok_bad = 1'b0;
        tok_active = 1'b0;
        case (ph)
            PH_MAGIC: begin
                if (magic == MG_OK) ph = PH_WIDTH;
                else abort_with(ERR_MAGIC);
                magic = MG_START;
            end
            PH_WIDTH, PH_HEIGHT: begin
                if (bad) note_error(ERR_NUMBER);
                else if (v > DIM_LIMIT) note_error(ERR_TOO_LARGE);
                if (v > DIM_LIMIT) v = DIM_LIMIT;
                if (ph == PH_WIDTH) begin
                    img_w = v[31:0];
                    ph = PH_HEIGHT;
                end else begin
                    img_h = v[31:0];
                    ph = PH_MAXVAL;
                end
            end
            PH_MAXVAL: begin
                if (bad) note_error(ERR_NUMBER);
                if (err == ERR_NONE && (img_w == 0 || img_h == 0)) note_error(ERR_ZERO_DIM);
                if (err == ERR_NONE && (v == 0 || v > SAMPLE_LIMIT)) note_error(ERR_MAXVAL);
                if (err != ERR_NONE) begin
                    ph = PH_FAIL;
                end else begin
                    img_max = v[31:0];
                    add_result(KIND_HEADER, 16'd0, 2'd0, 16'd0, 16'd0, img_w[15:0],
                               img_h[15:0], img_max[15:0], fmt, img_max > 32'd255, ERR_NONE);
                    col = 32'd0;
                    row = 32'd0;
                    plane = 2'd0;
                    hi_held = 1'b0;
                    if (fmt == FMT_P3) ph = PH_ASCII;
                    else ph = PH_BIN;
                end
            end
            PH_ASCII: begin
                if (bad) abort_with(ERR_NUMBER);
                else emit_pixel(v[15:0]);
            end
            default: ;
        endcase
    endfunction

    function void token_byte(logic [7:0] b);
        if (comment_open) begin
            if (b == CH_LF) comment_open = 1'b0;
            return;
        end
        if (b == CH_HASH || is_blank(b)) begin
            if (tok_active) close_token();
            if (b == CH_HASH) comment_open = 1'b1;
            return;
        end
        tok_active = 1'b1;
        if (ph == PH_MAGIC) begin
            case (magic)
                MG_START: begin
                    if (b == CH_P) magic = MG_GOT_P;
                    else magic = MG_BAD;
                end
                MG_GOT_P: begin
                    magic = MG_OK;
                    if (b == CH_5) fmt = FMT_P5;
                    else if (b == CH_6) fmt = FMT_P6;
                    else if (b == CH_3) fmt = FMT_P3;
                    else magic = MG_BAD;
                end
                default: magic = MG_BAD;
            endcase
        end else if (b >= CH_0 && b <= CH_9) begin
            acc = acc * 64'd10 + 64'(b - CH_0);
            if (ph == PH_ASCII) acc = acc & 64'hFFFF;
            else if (acc > ACC_LIMIT) acc = ACC_LIMIT;
        end else begin
            tok_bad = 1'b1;
        end
    endfunction

    function void raw_byte(logic [7:0] b);
        if (comment_open) begin
            if (b == CH_LF) comment_open = 1'b0;
            return;
        end
        if (img_max > 32'd255) begin
            if (!hi_held) begin
                hi_byte = b;
                hi_held = 1'b1;
                return;
            end
            hi_held = 1'b0;
            emit_pixel({hi_byte, b});
        end else begin
            emit_pixel({8'h00, b});
        end
    endfunction

    function void finish_file();
        if (ph == PH_MAGIC) begin
            if (tok_active && magic == MG_OK) err = ERR_HDR_CUT;
            else err = ERR_MAGIC;
        end else if (ph == PH_WIDTH || ph == PH_HEIGHT) begin
            err = ERR_HDR_CUT;
        end else if (ph == PH_MAXVAL) begin
            if (tok_active) close_token();
            else err = ERR_HDR_CUT;
        end
        if (ph == PH_ASCII && tok_active) close_token();
        if (ph == PH_BIN || ph == PH_ASCII) note_error(ERR_DATA_CUT);
        if (err != ERR_NONE)
            add_result(KIND_ERROR, 16'd0, 2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                       FMT_P5, 1'b0, err);
        else
            add_result(KIND_DONE, 16'd0, 2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                       FMT_P5, 1'b0, ERR_NONE);
        clear_parser();
    endfunction

    function void parse_byte(logic [7:0] b, logic eof);
        t_result res;
        byte_out.delete();
        case (ph)
            PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCII: token_byte(b);
            PH_BIN: raw_byte(b);
            default: ;
        endcase
        if (eof) finish_file();
        for (int k = 0; k < byte_out.size(); k++) begin
            res = byte_out[k];
            res.last_of_run = (k == byte_out.size() - 1);
            parsed_results.insert(parsed_results.size(), res);
        end
    endfunction

    // file generation
    function void put_byte(logic [7:0] b);
        file_buf.insert(file_buf.size(), b);
    endfunction

    function void put_text(string s);
        for (int k = 0; k < s.len(); k++) put_byte(s[k]);
    endfunction

    function void put_space();
        case ($urandom_range(3))
            0: put_byte(CH_SP);
            1: put_byte(CH_TAB);
            2: put_byte(CH_LF);
            default: put_byte(CH_CR);
        endcase
    endfunction

    function void put_comment();
        int         n;
        logic [7:0] b;
        put_byte(CH_HASH);
        n = $urandom_range(5);
        for (int k = 0; k < n; k++) begin
            do b = 8'($urandom_range(255)); while (b == CH_LF);
            put_byte(b);
        end
        put_byte(CH_LF);
    endfunction

    function void put_gap();
        int n;
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) put_comment();
            else put_space();
        end
    endfunction

    function void put_noise(int n);
        for (int k = 0; k < n; k++) put_byte(8'($urandom_range(255)));
    endfunction

    function int commit_file(bit drain);
        t_file_byte fb;
        int         n;
        n = file_buf.size();
        for (int k = 0; k < n; k++) begin
            fb.data = file_buf[k];
            fb.eof = (k == n - 1);
            fb.drain_first = drain && (k == 0);
            file_stream.insert(file_stream.size(), fb);
        end
        file_buf.delete();
        return n;
    endfunction

    function int make_file(bit drain);
        int      mode;
        int      w;
        int      h;
        int      maxv;
        int      count;
        int      cut;
        int      val;
        bit      header_ok;
        t_format f;
        string   magic_tok;
        string   w_tok;
        string   h_tok;
        string   m_tok;
        mode = $urandom_range(99);
        file_buf.delete();
        if (mode < 5) begin
            if ($urandom_range(1)) put_byte(CH_P);
            put_noise($urandom_range(1, 10));
            return commit_file(drain);
        end
        f = t_format'($urandom_range(2));
        w = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
        h = ($urandom_range(9) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
        case ($urandom_range(9))
            0: maxv = 1;
            1: maxv = 255;
            2: maxv = 256;
            3: maxv = 65535;
            4, 5, 6: maxv = $urandom_range(256, 65535);
            default: maxv = $urandom_range(1, 255);
        endcase
        case (f)
            FMT_P5: magic_tok = "P5";
            FMT_P6: magic_tok = "P6";
            default: magic_tok = "P3";
        endcase
        w_tok = $sformatf("%0d", w);
        h_tok = $sformatf("%0d", h);
        m_tok = $sformatf("%0d", maxv);
        if ($urandom_range(9) == 0) w_tok = {"0", w_tok};
        if ($urandom_range(9) == 0) m_tok = {"00", m_tok};
        header_ok = 1'b1;
        if (mode < 10) begin
            header_ok = 1'b0;
            case ($urandom_range(4))
                0: magic_tok = "P7";
                1: magic_tok = "P";
                2: magic_tok = "X5";
                3: magic_tok = "P55";
                default: magic_tok = "p6";
            endcase
        end else if (mode < 25) begin
            header_ok = 1'b0;
            case ($urandom_range(7))
                0: w_tok = "0";
                1: h_tok = "0";
                2: m_tok = "0";
                3: m_tok = "65536";
                4: w_tok = "99999999999999";
                5: h_tok = "65536";
                6: w_tok = {"-", w_tok};
                default: m_tok = {m_tok, "x"};
            endcase
        end
        if ($urandom_range(3) == 0) put_gap();
        put_text(magic_tok);
        put_gap();
        put_text(w_tok);
        put_gap();
        put_text(h_tok);
        put_gap();
        put_text(m_tok);
        count = w * h * ((f == FMT_P5) ? 1 : 3);
        if (!header_ok) begin
            put_noise($urandom_range(6));
        end else if (f == FMT_P3) begin
            for (int k = 0; k < count; k++) begin
                put_gap();
                case ($urandom_range(19))
                    0: val = -1;
                    1, 2, 3: val = $urandom_range(99999);
                    4: val = $urandom_range(65535);
                    default: val = $urandom_range(maxv);
                endcase
                if (val < 0) put_text("7z");
                else put_text($sformatf("%0d", val));
            end
            if ($urandom_range(1)) put_gap();
        end else begin
            if ($urandom_range(4) == 0) put_comment();
            else put_space();
            put_noise(count * ((maxv > 255) ? 2 : 1));
        end
        if (mode >= 25 && mode < 35) begin
            cut = $urandom_range(1, file_buf.size());
            while (file_buf.size() > cut) void'(file_buf.pop_back());
        end else if (mode >= 35 && mode < 45) begin
            put_noise($urandom_range(1, 4));
        end
        return commit_file(drain);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // byte driver and prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            clear_parser();
        end else begin
            if (i_in_valid && o_in_ready) parse_byte(i_data_byte, i_end_of_file);
            if (!i_in_valid || o_in_ready) begin
                if (file_stream.size() > 0 && $urandom_range(99) >= send_idle_pct &&
                    !(file_stream[0].drain_first &&
                      (parsed_results.size() != 0 || i_in_valid))) begin
                    next_byte = file_stream.pop_front();
                    i_data_byte <= next_byte.data;
                    i_end_of_file <= next_byte.eof;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (parsed_results.size() == 0) begin
                    $error("result transfer with nothing pending, kind %0d", o_kind);
                    errors++;
                end else begin
                    want = parsed_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(o_kind));
                    check_field("sample_value", want.sample_value, o_sample_value);
                    check_field("channel", 16'(want.channel), 16'(o_channel));
                    check_field("column", want.column, o_column);
                    check_field("row", want.row, o_row);
                    check_field("image_width", want.image_width, o_image_width);
                    check_field("image_height", want.image_height, o_image_height);
                    check_field("max_value", want.max_value, o_max_value);
                    check_field("format", 16'(want.format), 16'(o_format));
                    check_field("wide_samples", 16'(want.wide_samples), 16'(o_wide_samples));
                    check_field("error_code", 16'(want.error_code), 16'(o_error_code));
                    check_field("last_of_run", 16'(want.last_of_run), 16'(o_last_of_run));
                end
            end
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int added;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 51; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 51; end
                default: begin send_idle_pct = 7; stall_pct = 7; end
            endcase
            added = 0;
            if (p == 0) begin
                put_text("P5 1 1 65535\n");
                put_byte(8'hFF);
                put_byte(8'h00);
                added += commit_file(1'b1);
                put_text("P3#c\n1 1 1 70000");
                added += commit_file(1'b0);
                put_text("Q");
                added += commit_file(1'b0);
                put_text("P6 2");
                added += commit_file(1'b0);
            end
            while (added < PHASE_BYTES)
                added += make_file(added == 0 || $urandom_range(5) == 0);
            while (file_stream.size() != 0 || i_in_valid) @(posedge i_clk);
        end
        while (parsed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && parsed_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pnm_pkg.sv
hw/rtl/pnm_image_stream_parser.sv
hw/rtl/pnm_chk.sv
sim/pnm_image_stream_parser_tb.sv
